// ----- rtl/hee_pkg.sv -----
package hee_pkg;

  // Special byte values.
  localparam logic [7:0] LeadByte = 8'hC2;
  localparam logic [7:0] NbspTail = 8'hA0;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChQuot   = 8'h22;

  // Input item as it arrives on the push side.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } hee_in_t;

  // Result item as it leaves on the pop side.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } hee_out_t;

  // What the back end writes for one input byte, after an optional lead byte.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_NBSP
  } hee_kind_e;

  // One classified job passed from the front end to the back end.
  typedef struct packed {
    logic       lead;
    hee_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } hee_job_t;

  // Number of bytes written for the main part of a job.
  function automatic logic [2:0] kind_len(input hee_kind_e kind);
    logic [2:0] len;
    case (kind)
      KIND_NONE:  len = 3'd0;
      KIND_PLAIN: len = 3'd1;
      KIND_AMP:   len = 3'd5;
      KIND_LT:    len = 3'd4;
      KIND_GT:    len = 3'd4;
      KIND_QUOT:  len = 3'd6;
      KIND_NBSP:  len = 3'd6;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  // Byte at position pos of the main part of a job.
  function automatic logic [7:0] kind_char(input hee_kind_e kind, input logic [2:0] pos,
                                           input logic [7:0] data);
    logic [7:0] ch;
    ch = ";";
    case (kind)
      KIND_PLAIN: ch = data;
      KIND_AMP: begin
        case (pos)
          3'd0: ch = "&";
          3'd1: ch = "a";
          3'd2: ch = "m";
          3'd3: ch = "p";
          default: ch = ";";
        endcase
      end
      KIND_LT: begin
        case (pos)
          3'd0: ch = "&";
          3'd1: ch = "l";
          3'd2: ch = "t";
          default: ch = ";";
        endcase
      end
      KIND_GT: begin
        case (pos)
          3'd0: ch = "&";
          3'd1: ch = "g";
          3'd2: ch = "t";
          default: ch = ";";
        endcase
      end
      KIND_QUOT: begin
        case (pos)
          3'd0: ch = "&";
          3'd1: ch = "q";
          3'd2: ch = "u";
          3'd3: ch = "o";
          3'd4: ch = "t";
          default: ch = ";";
        endcase
      end
      KIND_NBSP: begin
        case (pos)
          3'd0: ch = "&";
          3'd1: ch = "n";
          3'd2: ch = "b";
          3'd3: ch = "s";
          3'd4: ch = "p";
          default: ch = ";";
        endcase
      end
      default: ch = data;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/hee_fifo.sv -----
module hee_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update with wrap at the last entry.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/hee_front.sv -----
module hee_front
  import hee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hee_in_t  in_data_i,
  output logic     full_o,
  input  logic     cfg_valid_i,
  input  logic     cfg_data_i,
  output logic     job_push_o,
  output hee_job_t job_o,
  input  logic     job_full_i
);

  logic      quote_escape_q;
  logic      held_q, held_d;
  logic      accept;
  logic      nbsp;
  hee_kind_e kind;

  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;
  assign nbsp   = held_q && (in_data_i.in_byte == NbspTail);

  // Classify the incoming byte.
  always_comb begin
    kind   = KIND_PLAIN;
    held_d = held_q;
    if (nbsp) begin
      kind = KIND_NBSP;
    end else begin
      unique case (in_data_i.in_byte)
        ChAmp:  kind = KIND_AMP;
        ChLt:   kind = KIND_LT;
        ChGt:   kind = KIND_GT;
        ChQuot: kind = quote_escape_q ? KIND_QUOT : KIND_PLAIN;
        LeadByte: kind = in_data_i.string_end ? KIND_PLAIN : KIND_NONE;
        default: kind = KIND_PLAIN;
      endcase
    end
    if (accept) begin
      held_d = (kind == KIND_NONE);
    end
  end

  // A held lead byte is written ahead of the job unless it became part of a space.
  always_comb begin
    job_o.lead = held_q && !nbsp;
    job_o.kind = kind;
    job_o.data = in_data_i.in_byte;
    job_o.last = in_data_i.string_end;
  end

  // A byte that is only held as a new lead byte pushes no job unless an earlier held lead byte must be written.
  assign job_push_o = accept && (job_o.lead || (kind != KIND_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q         <= 1'b0;
      quote_escape_q <= 1'b1;
    end else begin
      held_q <= held_d;
      if (cfg_valid_i) begin
        quote_escape_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- rtl/hee_back.sv -----
module hee_back
  import hee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hee_job_t job_i,
  input  logic     job_empty_i,
  output logic     job_pop_o,
  output logic     res_push_o,
  output hee_out_t res_o,
  input  logic     res_full_i
);

  logic [2:0] idx_q, idx_d;
  logic [2:0] len;
  logic [2:0] pos;
  logic       step;
  logic       final_byte;

  assign len        = kind_len(job_i.kind) + {2'b00, job_i.lead};
  assign pos        = idx_q - {2'b00, job_i.lead};
  assign step       = !job_empty_i && !res_full_i;
  assign final_byte = (idx_q == len - 3'd1);

  // Select the byte at the current position of the job.
  always_comb begin
    if (job_i.lead && (idx_q == 3'd0)) begin
      res_o.out_byte = LeadByte;
    end else begin
      res_o.out_byte = kind_char(job_i.kind, pos, job_i.data);
    end
    res_o.run_last  = final_byte;
    res_o.text_done = final_byte && job_i.last;
  end

  assign res_push_o = step;
  assign job_pop_o  = step && final_byte;

  // Walk through the bytes of the current job.
  always_comb begin
    idx_d = idx_q;
    if (step) begin
      idx_d = final_byte ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ----- rtl/html_entity_escape_top.sv -----
// Path: an input byte passes through the job queue and the output queue, both registered.
// Throughput: one result per cycle while the job queue holds a job and the output queue
// has room; an entity gives as many bytes as it has (up to seven), walked by the back end.
// Reset: asynchronous, active low; clears both queues and the held lead byte,
// and sets quote escaping on.
module html_entity_escape_top
  import hee_pkg::*;
#(
  parameter int JobDepth = 2,
  parameter int OutDepth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  hee_in_t  in_data_i,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output hee_out_t out_data_o,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data_i
);

  logic     job_push;
  hee_job_t job_in;
  logic     job_full;
  logic     job_pop;
  hee_job_t job_head;
  logic     job_empty;
  logic     res_push;
  hee_out_t res;
  logic     res_full;

  assign cfg_ready = 1'b1;

  // Front end: classify bytes and track the held lead byte.
  hee_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_data_i   (in_data_i),
    .full_o      (full),
    .cfg_valid_i (cfg_valid),
    .cfg_data_i  (cfg_data_i),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  // Queue of classified jobs.
  hee_fifo #(
    .Width ($bits(hee_job_t)),
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_head),
    .empty_o (job_empty)
  );

  // Back end: expand each job into output bytes.
  hee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // Output queue decouples the consumer from the expander.
  hee_fifo #(
    .Width ($bits(hee_out_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import hee_pkg::*;

  // Cycles to let pass once nothing is expected, covering a held lead byte.
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned CycleLimit   = 400000;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  hee_in_t  in_data;
  logic     full;
  logic     empty;
  logic     pop;
  hee_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;

  // Predictor state: quote mode and the held lead byte.
  logic quote_esc_q;
  logic lead_held_q;

  // Escaped bytes still to come out of the block, oldest first.
  hee_out_t escaped_q[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned sink_left;
  bit          sender_steady;
  bit          sink_steady;

  html_entity_escape_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_data_i (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data_i(cfg_data)
  );

  // Clock with a 2 ns period.
  always #1 clk_i = ~clk_i;

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Expected escaped text for one accepted byte, appended to the queue.
  task automatic escape_byte_model(input hee_in_t item);
    logic [7:0] text[$];
    string      ent;
    logic       taken;
    hee_out_t   res;
    ent   = "";
    taken = 1'b0;
    if (lead_held_q) begin
      lead_held_q = 1'b0;
      if (item.in_byte == NbspTail) begin
        ent   = "&nbsp;";
        taken = 1'b1;
      end else begin
        text.push_back(LeadByte);
      end
    end
    if (!taken) begin
      if (item.in_byte == ChAmp) begin
        ent = "&amp;";
      end else if (item.in_byte == ChLt) begin
        ent = "&lt;";
      end else if (item.in_byte == ChGt) begin
        ent = "&gt;";
      end else if (item.in_byte == ChQuot && quote_esc_q) begin
        ent = "&quot;";
      end else if (item.in_byte == LeadByte && !item.string_end) begin
        lead_held_q = 1'b1;
      end else begin
        text.push_back(item.in_byte);
      end
    end
    for (int i = 0; i < ent.len(); i++) begin
      text.push_back(ent[i]);
    end
    // Only the final byte of a step carries the end flags.
    for (int i = 0; i < text.size(); i++) begin
      res.out_byte  = text[i];
      res.run_last  = (i == text.size() - 1);
      res.text_done = (i == text.size() - 1) && item.string_end;
      escaped_q.push_back(res);
    end
  endtask

  // Offer one byte, wait for its transfer, then maybe idle for a while.
  task automatic send_byte(input logic [7:0] b, input logic last);
    hee_in_t     item;
    int unsigned n;
    item.in_byte    = b;
    item.string_end = last;
    push    <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (full);
    escape_byte_model(item);
    n = sender_steady ? 0 : gap_len();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Let every expected result drain, then give the block time to settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the quote mode register while the block is idle.
  task automatic write_quote_mode(input logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    quote_esc_q = v;
  endtask

  // Random text byte, weighted toward the bytes that get escaped.
  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return ChAmp;
    if (r < 15) return ChLt;
    if (r < 20) return ChGt;
    if (r < 30) return ChQuot;
    if (r < 45) return LeadByte;
    if (r < 50) return NbspTail;
    return 8'($urandom_range(0, 255));
  endfunction

  // One random string; a lead byte is usually followed by its tail.
  task automatic send_random_string(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      b = pick_text_byte();
      send_byte(b, i == len - 1);
      if (b == LeadByte && i + 1 < len && $urandom_range(0, 2) != 0) begin
        i++;
        send_byte(NbspTail, i == len - 1);
      end
    end
  endtask

  // Each result transfer is checked against the oldest expected byte.
  always @(posedge clk_i) begin
    hee_out_t want;
    if (rst_ni && pop && !empty) begin
      if (escaped_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $realtime, out_data);
        errors++;
      end else begin
        want = escaped_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $realtime, want.out_byte,
                   out_data.out_byte);
          errors++;
        end
        if (out_data.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $realtime, want.run_last,
                   out_data.run_last);
          errors++;
        end
        if (out_data.text_done !== want.text_done) begin
          $display("%0t: text_done expected %b actual %b", $realtime, want.text_done,
                   out_data.text_done);
          errors++;
        end
      end
    end
    // Receiver stalls at random unless held steady.
    if (sink_left > 0) begin
      pop <= 1'b0;
      sink_left--;
    end else begin
      pop <= 1'b1;
      if (!sink_steady) sink_left = gap_len();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Every escaped byte, the lead byte cases and a plain zero byte.
  task automatic test_directed_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChAmp, 1'b0);
    send_byte(ChLt, 1'b0);
    send_byte(ChGt, 1'b0);
    send_byte(ChQuot, 1'b1);
    send_byte(LeadByte, 1'b0);
    send_byte(NbspTail, 1'b0);
    // A second lead byte while one is held.
    send_byte(LeadByte, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(NbspTail, 1'b0);
    // A held lead byte followed by something else.
    send_byte(LeadByte, 1'b0);
    send_byte(ChAmp, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(8'h41, 1'b0);
    // A lead byte at the end of a string is written at once.
    send_byte(LeadByte, 1'b1);
    send_byte(LeadByte, 1'b0);
    send_byte(LeadByte, 1'b1);
    send_byte(NbspTail, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Quotes pass unchanged with escaping off, and escape again once it is on.
  task automatic test_quote_mode();
    write_quote_mode(1'b0);
    send_byte(ChQuot, 1'b0);
    send_byte(LeadByte, 1'b0);
    send_byte(ChQuot, 1'b0);
    send_byte(ChAmp, 1'b1);
    write_quote_mode(1'b1);
    send_byte(LeadByte, 1'b0);
    send_byte(ChQuot, 1'b1);
  endtask

  // The sender holds off until the block has given every expected result.
  task automatic test_drain_pause();
    send_random_string(6);
    send_byte(LeadByte, 1'b0);
    push <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    send_byte(NbspTail, 1'b1);
    send_random_string(5);
  endtask

  // Random strings in phases, each with its own quote mode and idling.
  task automatic test_random_text();
    int unsigned sent;
    int unsigned len;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) write_quote_mode(1'b0);
      else if (phase == 1) write_quote_mode(1'b1);
      else write_quote_mode(1'($urandom_range(0, 1)));
      sender_steady = (phase == 2);
      sink_steady   = (phase == 2);
      sent = 0;
      while (sent < 60) begin
        len = $urandom_range(1, 10);
        send_random_string(len);
        sent += len;
      end
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    in_data       = '0;
    pop           = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    errors        = 0;
    cycles        = 0;
    sink_left     = 0;
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    quote_esc_q   = 1'b1;
    lead_held_q   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_bytes();
    test_quote_mode();
    test_drain_pause();
    test_random_text();

    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- html_entity_escape_top.f -----
rtl/hee_pkg.sv
rtl/hee_fifo.sv
rtl/hee_front.sv
rtl/hee_back.sv
rtl/html_entity_escape_top.sv
tb/tb_top.sv
